/* rtl/core/lsc_pkg.sv */
// Shared types, codes and constants for the proximity lid stepper controller.
// No dependencies; every other file in rtl/core uses this package.
`default_nettype none

package lsc_pkg;

   // Field widths
   localparam int DIST_W      = 9;
   localparam int OPCODE_W    = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 9;
   localparam int REQ_DATA_W  = 16;
   localparam int REQ_USER_W  = 8;
   localparam int RSP_DATA_W  = 16;
   localparam int NUM_EVENTS  = 3;

   // Stepper phase positions
   localparam logic [1:0] PHASE_FIRST = 2'd0;
   localparam logic [1:0] PHASE_LAST  = 2'd3;

   // Reset values of the configuration registers
   localparam logic [8:0] RST_NEAR_THR    = 9'd20;
   localparam logic [5:0] RST_CLOSE_DELAY = 6'd10;
   localparam logic [3:0] RST_BUZZ_LIMIT  = 4'd3;
   localparam logic [2:0] RST_CYCLES      = 3'd4;
   localparam logic [3:0] RST_PHASE_HOLD  = 4'd5;
   localparam logic [7:0] RST_TICKS_SEC   = 8'd100;

   typedef enum logic [OPCODE_W-1:0] {
      OP_TICK   = 2'd0,
      OP_SAMPLE = 2'd1,
      OP_PRESS  = 2'd2,
      OP_ALARM  = 2'd3
   } lsc_opcode_type;

   // Event codes double as bits of the pending mask
   typedef enum logic [2:0] {
      EV_NONE  = 3'b000,
      EV_CLOSE = 3'b001,
      EV_OPEN  = 3'b010,
      EV_PRESS = 3'b100
   } lsc_event_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NEAR_THR    = 3'd0,
      CSR_CLOSE_DELAY = 3'd1,
      CSR_BUZZ_LIMIT  = 3'd2,
      CSR_CYCLES      = 3'd3,
      CSR_PHASE_HOLD  = 3'd4,
      CSR_TICKS_SEC   = 3'd5
   } lsc_csr_index_type;

   typedef struct packed {
      logic [8:0] near_thr;
      logic [5:0] close_delay;
      logic [3:0] buzz_limit;
      logic [2:0] cycles_per_move;
      logic [3:0] phase_hold;
      logic [7:0] ticks_per_sec;
   } lsc_cfg_type;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [DIST_W-1:0]   distance_cm;
   } lsc_item_type;

   typedef struct packed {
      logic       lid;
      logic       manual;
      logic       moving;
      logic       dir;
      logic [2:0] cycles_left;
      logic [1:0] phase_pos;
      logic [3:0] phase_timer;
      logic [7:0] prescaler;
      logic [5:0] lid_sec;
      logic [3:0] buzz_sec;
      logic       buzzer;
      logic [3:0] coil;
      logic [2:0] pending;
   } lsc_state_type;

   typedef struct packed {
      logic [3:0] coil_drive;
      logic       buzzer_active;
      logic       lid_is_open;
      logic       manual_on;
      logic       motor_moving;
      logic       alarm_ack;
   } lsc_result_type;

   // Clockwise coil order 4,2,8,1
   function automatic logic [3:0] phase_code(input logic [1:0] pos);
      logic [3:0] code;
      case (pos)
         2'd0:    code = 4'h4;
         2'd1:    code = 4'h2;
         2'd2:    code = 4'h8;
         default: code = 4'h1;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/lsc_csr.sv */
// Configuration register bank for the lid controller.
// Depends on lsc_pkg for register indexes, reset values and the config struct.
`default_nettype none

module lsc_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [lsc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [lsc_pkg::CSR_DATA_W-1:0]   csr_data,
   output lsc_pkg::lsc_cfg_type                  cfg
);

   lsc_pkg::lsc_cfg_type cfg_ff;
   lsc_pkg::lsc_cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode one write beat; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (lsc_pkg::lsc_csr_index_type'(csr_index))
            lsc_pkg::CSR_NEAR_THR:    cfg_in.near_thr        = csr_data[8:0];
            lsc_pkg::CSR_CLOSE_DELAY: cfg_in.close_delay     = csr_data[5:0];
            lsc_pkg::CSR_BUZZ_LIMIT:  cfg_in.buzz_limit      = csr_data[3:0];
            lsc_pkg::CSR_CYCLES:      cfg_in.cycles_per_move = csr_data[2:0];
            lsc_pkg::CSR_PHASE_HOLD:  cfg_in.phase_hold      = csr_data[3:0];
            lsc_pkg::CSR_TICKS_SEC:   cfg_in.ticks_per_sec   = csr_data[7:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.near_thr        <= lsc_pkg::RST_NEAR_THR;
         cfg_ff.close_delay     <= lsc_pkg::RST_CLOSE_DELAY;
         cfg_ff.buzz_limit      <= lsc_pkg::RST_BUZZ_LIMIT;
         cfg_ff.cycles_per_move <= lsc_pkg::RST_CYCLES;
         cfg_ff.phase_hold      <= lsc_pkg::RST_PHASE_HOLD;
         cfg_ff.ticks_per_sec   <= lsc_pkg::RST_TICKS_SEC;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/lsc_in_reg.sv */
// Input register stage: holds one request beat until the engine takes it.
// Depends on lsc_pkg for the item struct.
`default_nettype none

module lsc_in_reg (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire lsc_pkg::lsc_item_type in_item,
   output logic                      out_valid,
   input  wire logic                 out_take,
   output lsc_pkg::lsc_item_type     out_item
);

   logic                  valid_ff;
   logic                  valid_in;
   lsc_pkg::lsc_item_type item_ff;

   // Free when empty or when the held beat leaves this cycle
   assign in_ready  = !valid_ff || out_take;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;
   assign valid_in  = (in_valid && in_ready) || (valid_ff && !out_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/lsc_engine.sv */
// Lid, stepper, timer and buzzer state with its combinational update and the
// result register. Depends on lsc_pkg for state, config, item and result types.
`default_nettype none

module lsc_engine (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire lsc_pkg::lsc_cfg_type  cfg,
   input  wire logic                  item_valid,
   output logic                       item_take,
   input  wire lsc_pkg::lsc_item_type item,
   output logic                       res_valid,
   input  wire logic                  res_ready,
   output lsc_pkg::lsc_result_type    res
);

   lsc_pkg::lsc_state_type  state_ff;
   lsc_pkg::lsc_state_type  state_in;
   logic                    ack_in;
   logic                    res_valid_ff;
   logic                    res_valid_in;
   lsc_pkg::lsc_result_type res_ff;
   logic                    fire;

   // Begin a move; a zero cycle count finishes it on the spot
   function automatic lsc_pkg::lsc_state_type start_move(
      input lsc_pkg::lsc_state_type s,
      input logic                   dir,
      input lsc_pkg::lsc_cfg_type   c
   );
      lsc_pkg::lsc_state_type r;
      r = s;
      if (c.cycles_per_move == 3'd0) begin
         r.lid = dir;
      end else begin
         r.moving      = 1'b1;
         r.dir         = dir;
         r.cycles_left = c.cycles_per_move;
         r.phase_pos   = lsc_pkg::PHASE_FIRST;
         r.phase_timer = 4'd0;
         r.coil = lsc_pkg::phase_code(dir ? lsc_pkg::PHASE_FIRST : lsc_pkg::PHASE_LAST);
      end
      return r;
   endfunction

   // Act on one close, open or press event
   function automatic lsc_pkg::lsc_state_type do_event(
      input lsc_pkg::lsc_state_type s,
      input lsc_pkg::lsc_event_type ev,
      input lsc_pkg::lsc_cfg_type   c
   );
      lsc_pkg::lsc_state_type r;
      r = s;
      case (ev)
         lsc_pkg::EV_CLOSE: begin
            if (r.lid && !r.manual) r = start_move(r, 1'b0, c);
         end
         lsc_pkg::EV_OPEN: begin
            r.lid_sec = 6'd0;
            if (!r.lid && !r.manual) r = start_move(r, 1'b1, c);
         end
         lsc_pkg::EV_PRESS: begin
            if (!r.lid) begin
               r.manual = 1'b1;
               r = start_move(r, 1'b1, c);
            end else begin
               r = start_move(r, 1'b0, c);
               r.manual = 1'b0;
            end
         end
         default: r = s;
      endcase
      return r;
   endfunction

   // Hold the event while moving, otherwise act now
   function automatic lsc_pkg::lsc_state_type raise_event(
      input lsc_pkg::lsc_state_type s,
      input lsc_pkg::lsc_event_type ev,
      input lsc_pkg::lsc_cfg_type   c
   );
      lsc_pkg::lsc_state_type r;
      r = s;
      if (r.moving) r.pending = r.pending | ev;
      else          r = do_event(r, ev, c);
      return r;
   endfunction

   // Work off held events in close, open, press order until a move starts
   function automatic lsc_pkg::lsc_state_type drain(
      input lsc_pkg::lsc_state_type s,
      input lsc_pkg::lsc_cfg_type   c
   );
      lsc_pkg::lsc_state_type r;
      r = s;
      for (int i = 0; i < lsc_pkg::NUM_EVENTS; i++) begin
         if (!r.moving && r.pending != 3'd0) begin
            if ((r.pending & lsc_pkg::EV_CLOSE) != 3'd0) begin
               r.pending = r.pending & ~lsc_pkg::EV_CLOSE;
               r = do_event(r, lsc_pkg::EV_CLOSE, c);
            end else if ((r.pending & lsc_pkg::EV_OPEN) != 3'd0) begin
               r.pending = r.pending & ~lsc_pkg::EV_OPEN;
               r = do_event(r, lsc_pkg::EV_OPEN, c);
            end else begin
               r.pending = r.pending & ~lsc_pkg::EV_PRESS;
               r = do_event(r, lsc_pkg::EV_PRESS, c);
            end
         end
      end
      return r;
   endfunction

   // One motor tick: phase hold, phase advance, end of move
   function automatic lsc_pkg::lsc_state_type motor_tick(
      input lsc_pkg::lsc_state_type s,
      input lsc_pkg::lsc_cfg_type   c
   );
      lsc_pkg::lsc_state_type r;
      logic [3:0]             t;
      r = s;
      t = r.phase_timer + 4'd1;
      if (r.moving) begin
         if (t < c.phase_hold) begin
            r.phase_timer = t;
         end else begin
            r.phase_timer = 4'd0;
            if (r.phase_pos == lsc_pkg::PHASE_LAST) begin
               r.cycles_left = r.cycles_left - 3'd1;
               if (r.cycles_left == 3'd0) begin
                  r.moving = 1'b0;
                  r.lid    = r.dir;
                  r = drain(r, c);
               end else begin
                  r.phase_pos = lsc_pkg::PHASE_FIRST;
                  r.coil = lsc_pkg::phase_code(r.dir ? r.phase_pos
                                                     : lsc_pkg::PHASE_LAST - r.phase_pos);
               end
            end else begin
               r.phase_pos = r.phase_pos + 2'd1;
               r.coil = lsc_pkg::phase_code(r.dir ? r.phase_pos
                                                  : lsc_pkg::PHASE_LAST - r.phase_pos);
            end
         end
      end
      return r;
   endfunction

   // Engine takes the held beat whenever the result slot is free or draining
   assign fire      = item_valid && (!res_valid_ff || res_ready);
   assign item_take = fire;
   assign res_valid = res_valid_ff;
   assign res       = res_ff;
   assign res_valid_in = fire || (res_valid_ff && !res_ready);

   // Next state for the beat in the input register
   always_comb begin
      state_in = state_ff;
      ack_in   = 1'b0;
      case (lsc_pkg::lsc_opcode_type'(item.opcode))
         lsc_pkg::OP_TICK: begin
            state_in = motor_tick(state_in, cfg);
            state_in.prescaler = state_in.prescaler + 8'd1;
            if (state_in.prescaler >= cfg.ticks_per_sec) begin
               state_in.prescaler = 8'd0;
               if (state_in.buzzer) begin
                  state_in.buzz_sec = state_in.buzz_sec + 4'd1;
                  if (state_in.buzz_sec >= cfg.buzz_limit) begin
                     state_in.buzz_sec = 4'd0;
                     state_in.buzzer   = 1'b0;
                     ack_in            = 1'b1;
                  end
               end
               state_in.lid_sec = state_in.lid_sec + 6'd1;
               if (state_in.lid_sec >= cfg.close_delay) begin
                  state_in.lid_sec = 6'd0;
                  state_in = raise_event(state_in, lsc_pkg::EV_CLOSE, cfg);
               end
            end
         end
         lsc_pkg::OP_SAMPLE: begin
            if (!state_in.manual && item.distance_cm != '0
                && item.distance_cm <= cfg.near_thr) begin
               state_in = raise_event(state_in, lsc_pkg::EV_OPEN, cfg);
            end
         end
         lsc_pkg::OP_PRESS: begin
            state_in = raise_event(state_in, lsc_pkg::EV_PRESS, cfg);
         end
         lsc_pkg::OP_ALARM: begin
            state_in.buzzer   = 1'b1;
            state_in.buzz_sec = 4'd0;
         end
         default: state_in = state_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         res_valid_ff <= res_valid_in;
         if (fire) state_ff <= state_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (fire) begin
         res_ff.coil_drive    <= state_in.coil;
         res_ff.buzzer_active <= state_in.buzzer;
         res_ff.lid_is_open   <= state_in.lid;
         res_ff.manual_on     <= state_in.manual;
         res_ff.motor_moving  <= state_in.moving;
         res_ff.alarm_ack     <= ack_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/proximity_lid_stepper_controller.sv */
// Top level of the proximity lid stepper controller: config bank, input
// register and state engine. Depends on lsc_pkg, lsc_csr, lsc_in_reg, lsc_engine.
//
//   channel   direction  ports                          beat
//   req       in         req_tvalid/tready/tdata/tuser  one event
//   rsp       out        rsp_tvalid/tready/tdata        one status word per event
//   csr       in         csr_valid/ready/index/data     one register write
//
// One event per cycle sustained while rsp_tready is high. A request beat is
// first taken into the input register; the state update is computed from it
// combinationally, and the state and result registers load together when the
// engine takes the beat, which makes its rsp beat valid.
// Reset is synchronous and active high: lid closed, automatic mode, coils off,
// timers cleared, registers at their default values.
// With rsp_tready low the result holds and one more request beat is buffered,
// after which req_tready drops. csr_ready is always high.
`default_nettype none

module proximity_lid_stepper_controller (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // [8:0] distance_cm, [15:9] zero
   input  wire logic [lsc_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [1:0] opcode, [7:2] zero
   input  wire logic [lsc_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // [3:0] coil_drive, [4] buzzer_active, [5] lid_is_open, [6] manual_on,
   // [7] motor_moving, [8] alarm_ack, [15:9] zero
   output logic [lsc_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [lsc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [lsc_pkg::CSR_DATA_W-1:0]   csr_data
);

   lsc_pkg::lsc_cfg_type    cfg;
   lsc_pkg::lsc_item_type   req_item;
   lsc_pkg::lsc_item_type   held_item;
   logic                    held_valid;
   logic                    held_take;
   lsc_pkg::lsc_result_type res;

   assign req_item.opcode      = req_tuser[lsc_pkg::OPCODE_W-1:0];
   assign req_item.distance_cm = req_tdata[lsc_pkg::DIST_W-1:0];

   lsc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   lsc_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .out_valid (held_valid),
      .out_take  (held_take),
      .out_item  (held_item)
   );

   lsc_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (held_valid),
      .item_take  (held_take),
      .item       (held_item),
      .res_valid  (rsp_tvalid),
      .res_ready  (rsp_tready),
      .res        (res)
   );

   // Pack the status word, highest field first
   assign rsp_tdata = {7'd0, res.alarm_ack, res.motor_moving, res.manual_on,
                       res.lid_is_open, res.buzzer_active, res.coil_drive};

endmodule

`default_nettype wire
